### design/order_crossover_permutation_core_defines.svh
// Assertion macros used by the order crossover datapath.
// Each macro expands to one labeled concurrent assertion clocked on clk and
// disabled while arst_n is low.
`ifndef ORDER_CROSSOVER_PERMUTATION_CORE_DEFINES_SVH
`define ORDER_CROSSOVER_PERMUTATION_CORE_DEFINES_SVH

// The condition must never be true.
`define OCX_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// Whenever ante holds, cons must hold in the same cycle.
`define OCX_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### design/ocx_pkg.sv
package ocx_pkg;

	// Default and hard limit of the permutation length.
	localparam int MAX_CLIENTS_DEF = 256;
	localparam int STORE_CAP       = 256;

	// Fixed field widths.
	localparam int POS_W  = 8;
	localparam int CUST_W = 9;
	localparam int NUM_W  = 9;

	// The seen map covers every possible customer id.
	localparam int ID_SPACE = 1 << CUST_W;

	localparam logic [NUM_W-1:0] NUM_CLIENTS_RST = NUM_W'(256);

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_LOAD  = 2'd0;
	localparam opcode_t OP_CROSS = 2'd1;
	localparam opcode_t OP_READ  = 2'd2;

	localparam logic REPLY_DONE = 1'b0;
	localparam logic REPLY_READ = 1'b1;
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_BAD_CUT = 1'b1;

	typedef struct packed {
		opcode_t            opcode;
		logic [POS_W-1:0]   position;
		logic [CUST_W-1:0]  first_parent_customer;
		logic [CUST_W-1:0]  second_parent_customer;
		logic [POS_W-1:0]   cut_start;
		logic [POS_W-1:0]   cut_end;
	} req_t;

	typedef struct packed {
		logic               reply_kind;
		logic               status;
		logic [POS_W-1:0]   child_position;
		logic [CUST_W-1:0]  child_customer;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CLEAR,
		S_COPY,
		S_FILL,
		S_DRAIN,
		S_DONE
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load_we;
		logic read_issue;
		logic cross_start;
		logic clr_step;
		logic copy_step;
		logic fill_step;
		logic out_load_read;
		logic out_load_done;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic cut_bad;
		logic clr_last;
		logic copy_at_stop;
		logic fill_last;
		logic pipe_busy;
		logic out_free;
	} stat_t;

endpackage

### design/order_crossover_permutation_core.sv
// Order crossover (OX) engine for two customer permutations.
// Requests arrive on req/req_valid and are held off by req_stall; replies leave
// on rsp/rsp_valid and are held by rsp_stall. A request is taken on a clock edge
// with req_valid high and req_stall low. The client count is written through
// cfg_valid/cfg_data, which is always ready; the user must write it only while
// the engine is idle, as the block does not enforce this. A load request
// produces no reply. A read request reads the child store, then loads the
// reply register once that register is free. A crossover with a bad cut
// point goes straight to loading its done reply. A valid crossover sweeps
// all 512 ids of the seen map clear, copies the kept segment at one position a
// cycle, walks the second parent over the client count positions, drains a
// two-stage lookup pipe and then loads its done reply. Only one request is
// worked on at a time; a held reply does not block a following load. Reset
// clears the state machine and the reply valid flag and sets the client count
// to 256; the parent and child stores hold nothing defined until written.
// While the receiver stalls, the reply stays in place and the engine waits
// before loading the next one.
module order_crossover_permutation_core
	import ocx_pkg::*;
#(
	parameter int MAX_CLIENTS = MAX_CLIENTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [NUM_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	// The client count register accepts a write in any cycle.
	assign cfg_ready = 1'b1;

	// The controller sequences each request; it sees the request valid and opcode and the status flags.
	ocx_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_opcode (req.opcode),
		.req_stall  (req_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	// The datapath holds the stores, the seen map, the walk pointers and
	// the reply register.
	ocx_dp #(
		.MAX_CLIENTS (MAX_CLIENTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

### design/ocx_ctrl.sv
module ocx_ctrl
	import ocx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  opcode_t req_opcode,
	output logic    req_stall,
	input  stat_t   stat,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   accept;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_opcode)
						OP_LOAD: begin
							cmd.load_we = 1'b1;
						end
						OP_CROSS: begin
							cmd.cross_start = 1'b1;
							state_d = stat.cut_bad ? S_DONE : S_CLEAR;
						end
						OP_READ: begin
							cmd.read_issue = 1'b1;
							state_d = S_READ;
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				if (stat.out_free) begin
					cmd.out_load_read = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_COPY;
				end
			end
			S_COPY: begin
				if (stat.copy_at_stop) begin
					state_d = S_FILL;
				end else begin
					cmd.copy_step = 1'b1;
				end
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (stat.fill_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load_done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### design/ocx_dp.sv
`include "order_crossover_permutation_core_defines.svh"

module ocx_dp
	import ocx_pkg::*;
#(
	parameter int MAX_CLIENTS = MAX_CLIENTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  req_t             req,
	input  logic             cfg_valid,
	input  logic [NUM_W-1:0] cfg_data,
	input  logic             rsp_stall,
	output logic             rsp_valid,
	output rsp_t             rsp,
	input  cmd_t             cmd,
	output stat_t            stat
);

	localparam int STORE_DEPTH = (MAX_CLIENTS < STORE_CAP) ? MAX_CLIENTS : STORE_CAP;
	localparam int AW          = $clog2(STORE_DEPTH);

	typedef logic [AW-1:0] addr_t;

	// Advance a tour position by one, wrapping at the client count.
	function automatic addr_t next_pos(addr_t p, logic [NUM_W-1:0] n);
		logic [NUM_W-1:0] s;
		s = NUM_W'(p) + NUM_W'(1);
		return (s == n) ? '0 : addr_t'(s);
	endfunction

	// Configuration and the client count in use.
	logic [NUM_W-1:0] num_clients_q, n_use;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clients_q <= NUM_CLIENTS_RST;
		end else if (cfg_valid) begin
			num_clients_q <= cfg_data;
		end
	end

	assign n_use = (num_clients_q > NUM_W'(STORE_DEPTH)) ? NUM_W'(STORE_DEPTH) : num_clients_q;

	// Storage.
	logic [CUST_W-1:0] p1_mem    [STORE_DEPTH];
	logic [CUST_W-1:0] p2_mem    [STORE_DEPTH];
	logic [CUST_W-1:0] child_mem [STORE_DEPTH];
	logic              seen_mem  [ID_SPACE];

	logic [CUST_W-1:0] p1_rd_q, p2_rd_q, child_rd_q;
	logic              seen_rd_q;

	// Walk registers.
	addr_t              p_q, stop_q, q_q, cnt_q, p_s1;
	logic [CUST_W-1:0]  clr_q, cust_s2;
	logic               err_q;
	logic [POS_W-1:0]   rd_pos_q;
	logic               rd_oob_q;
	logic               c_v_s1, f_v_s1, f_v_s2;
	logic               out_valid_q;
	rsp_t               rsp_q;

	logic  pos_ok;
	addr_t pos_a;
	logic  fill_wr;

	assign pos_ok  = {1'b0, req.position} < NUM_W'(STORE_DEPTH);
	assign pos_a   = addr_t'(req.position);
	assign fill_wr = f_v_s2 && !seen_rd_q;

	// Parent stores: written by loads, read by the copy and fill walks.
	always_ff @(posedge clk) begin
		if (cmd.load_we && pos_ok) begin
			p1_mem[pos_a] <= req.first_parent_customer;
		end
		p1_rd_q <= p1_mem[p_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_we && pos_ok) begin
			p2_mem[pos_a] <= req.second_parent_customer;
		end
		p2_rd_q <= p2_mem[q_q];
	end

	// Child store: the copy stage and the fill stage never write in the same cycle.
	logic              cw_en;
	addr_t             cw_addr;
	logic [CUST_W-1:0] cw_data;

	always_comb begin
		cw_en   = 1'b0;
		cw_addr = p_s1;
		cw_data = p1_rd_q;
		if (c_v_s1) begin
			cw_en = 1'b1;
		end else if (fill_wr) begin
			cw_en   = 1'b1;
			cw_addr = p_q;
			cw_data = cust_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cw_en) begin
			child_mem[cw_addr] <= cw_data;
		end
		if (cmd.read_issue) begin
			child_rd_q <= child_mem[pos_a];
		end
	end

	// Seen map: swept clear at the start of each crossover, set by the copy.
	logic              sw_en, sw_data;
	logic [CUST_W-1:0] sw_addr;

	always_comb begin
		sw_en   = 1'b0;
		sw_addr = clr_q;
		sw_data = 1'b0;
		if (cmd.clr_step) begin
			sw_en = 1'b1;
		end else if (c_v_s1) begin
			sw_en   = 1'b1;
			sw_addr = p1_rd_q;
			sw_data = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sw_en) begin
			seen_mem[sw_addr] <= sw_data;
		end
		seen_rd_q <= seen_mem[p2_rd_q];
	end

	// Pointers and the captured request.
	always_ff @(posedge clk) begin
		if (cmd.cross_start) begin
			err_q  <= stat.cut_bad;
			p_q    <= addr_t'(req.cut_start);
			stop_q <= next_pos(addr_t'(req.cut_end), n_use);
			q_q    <= next_pos(addr_t'(req.cut_end), n_use);
			cnt_q  <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + CUST_W'(1);
			end
			if (cmd.copy_step || fill_wr) begin
				p_q <= next_pos(p_q, n_use);
			end
			if (cmd.fill_step) begin
				q_q   <= next_pos(q_q, n_use);
				cnt_q <= cnt_q + AW'(1);
			end
		end
		if (cmd.read_issue) begin
			rd_pos_q <= req.position;
			rd_oob_q <= !pos_ok;
		end
		p_s1    <= p_q;
		cust_s2 <= p2_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_v_s1 <= 1'b0;
			f_v_s1 <= 1'b0;
			f_v_s2 <= 1'b0;
		end else begin
			c_v_s1 <= cmd.copy_step;
			f_v_s1 <= cmd.fill_step;
			f_v_s2 <= f_v_s1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load_read || cmd.out_load_done) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load_read) begin
			rsp_q.reply_kind     <= REPLY_READ;
			rsp_q.status         <= ST_OK;
			rsp_q.child_position <= rd_pos_q;
			rsp_q.child_customer <= rd_oob_q ? '0 : child_rd_q;
		end else if (cmd.out_load_done) begin
			rsp_q.reply_kind     <= REPLY_DONE;
			rsp_q.status         <= err_q ? ST_BAD_CUT : ST_OK;
			rsp_q.child_position <= '0;
			rsp_q.child_customer <= '0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	// Status.
	assign stat.cut_bad      = ({1'b0, req.cut_start} >= n_use) || ({1'b0, req.cut_end} >= n_use);
	assign stat.clr_last     = &clr_q;
	assign stat.copy_at_stop = (p_q == stop_q);
	assign stat.fill_last    = (cnt_q == addr_t'(n_use - NUM_W'(1)));
	assign stat.pipe_busy    = c_v_s1 || f_v_s1 || f_v_s2;
	assign stat.out_free     = !out_valid_q || !rsp_stall;

	logic p_in_range, out_load;

	assign p_in_range = NUM_W'(p_q) < n_use;
	assign out_load   = cmd.out_load_read || cmd.out_load_done;

	`OCX_NEVER(a_child_port_clash, c_v_s1 && f_v_s2, "copy and fill write the child together")
	`OCX_IMPLY(a_ptr_range, c_v_s1 || f_v_s2, p_in_range, "child pointer beyond client count")
	`OCX_IMPLY(a_out_free, out_load, stat.out_free, "reply loaded over an untaken reply")
	`OCX_IMPLY(a_done_drained, cmd.out_load_done, !stat.pipe_busy, "done reply before walk drained")

endmodule
